[design/ses_pkg.sv]
// shared types, codes and helpers for the spectrum energy sampler
`default_nettype none

package ses_pkg;

    localparam int DEF_MAX_BINS  = 256;
    localparam int DEF_MAX_LINES = 16;
    localparam int DEF_RAND_BITS = 16;

    localparam int SLOT_W    = 8;
    localparam int WEIGHT_W  = 24;
    localparam int LENERGY_W = 16;
    localparam int RAND_W    = 16;
    localparam int ENERGY_W  = 17;
    localparam int STATUS_W  = 2;
    localparam int ACTION_W  = 2;
    localparam int CTOT_W    = 32;
    localparam int DTOT_W    = 28;
    localparam int TOT_W     = 33;
    localparam int CHAN_W    = 9;
    localparam int LINES_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;

    localparam logic [ACTION_W-1:0] ACT_LOAD_BIN  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_LINE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DRAW      = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_CONT  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_LINE  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RETRY = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_CONT_CHANNELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISC_LINES    = 2'd1;

    typedef struct packed {
        logic                 bin_we;
        logic                 line_we;
        logic [SLOT_W-1:0]    slot;
        logic [WEIGHT_W-1:0]  weight;
        logic [LENERGY_W-1:0] line_energy;
    } ses_load_t;

    typedef struct packed {
        logic [LENERGY_W-1:0] energy;
        logic [DTOT_W-1:0]    cum;
    } ses_line_t;

    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

`default_nettype wire

[design/spectrum_energy_sampler.sv]
// spectrum energy sampler: bin and line memories, draw sequencer, config registers
// loads leave busy low; a draw holds busy until its result, but a draw on an empty spectrum never raises it
// result strobe: empty spectrum direct from idle; continuous trial via PMUL, PCMP, BMUL, BRD, BCMP;
// discrete line via PMUL, PCMP, DMUL, then DWALK over k (1 to MAX_LINES) table entries walked
// the line walk reads one cumulative entry per cycle from the line memory; results cannot be stalled
// reset clears config, totals and peak; memories are undefined until loaded, no clearing pass
`default_nettype none

module spectrum_energy_sampler #(
    parameter int MAX_BINS  = ses_pkg::DEF_MAX_BINS,
    parameter int MAX_LINES = ses_pkg::DEF_MAX_LINES,
    parameter int RAND_BITS = ses_pkg::DEF_RAND_BITS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [ses_pkg::ACTION_W-1:0]       action,
    input  wire logic [ses_pkg::SLOT_W-1:0]         slot,
    input  wire logic [ses_pkg::WEIGHT_W-1:0]       weight,
    input  wire logic [ses_pkg::LENERGY_W-1:0]      line_energy,
    input  wire logic [ses_pkg::RAND_W-1:0]         rand_part,
    input  wire logic [ses_pkg::RAND_W-1:0]         rand_energy,
    input  wire logic [ses_pkg::RAND_W-1:0]         rand_accept,
    output logic                                    done,
    output logic      [ses_pkg::ENERGY_W-1:0]       energy,
    output logic      [ses_pkg::STATUS_W-1:0]       status,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ses_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ses_pkg::CFG_DAT_W-1:0]      cfg_data
);
    import ses_pkg::*;

    localparam int BA_W  = addr_w(MAX_BINS);
    localparam int LA_W  = addr_w(MAX_LINES);
    localparam int N_W   = $clog2(MAX_BINS + 1);
    localparam int M_W   = $clog2(MAX_LINES + 1);
    localparam int NC_W  = (N_W > CHAN_W) ? N_W : CHAN_W;
    localparam int MC_W  = (M_W > LINES_W) ? M_W : LINES_W;

    logic [CHAN_W-1:0]   chan_reg;
    logic [LINES_W-1:0]  lines_reg;
    logic [NC_W-1:0]     chan_ext;
    logic [MC_W-1:0]     lines_ext;
    logic [N_W-1:0]      bins_used;
    logic [M_W-1:0]      lines_used;
    logic                accept;
    logic                cfg_beat;
    ses_load_t           load;
    logic [BA_W-1:0]     bin_rd_addr;
    logic [LA_W-1:0]     line_rd_addr;
    logic [WEIGHT_W-1:0] bin_rd_data;
    ses_line_t           line_rd_data;
    logic [CTOT_W-1:0]   cont_total;
    logic [DTOT_W-1:0]   disc_total;
    logic [WEIGHT_W-1:0] bin_peak;

    assign cfg_ready = 1'b1;
    assign cfg_beat  = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg  <= '0;
            lines_reg <= '0;
        end
        else if (cfg_beat)
        begin
            if (cfg_index == REG_CONT_CHANNELS)
            begin
                chan_reg <= cfg_data[CHAN_W-1:0];
            end
            if (cfg_index == REG_DISC_LINES)
            begin
                lines_reg <= cfg_data[LINES_W-1:0];
            end
        end
    end

    // counts above the table sizes act as the table size
    always_comb
    begin
        chan_ext   = NC_W'(chan_reg);
        lines_ext  = MC_W'(lines_reg);
        bins_used  = (chan_ext > NC_W'(MAX_BINS)) ? N_W'(MAX_BINS) : N_W'(chan_ext);
        lines_used = (lines_ext > MC_W'(MAX_LINES)) ? M_W'(MAX_LINES) : M_W'(lines_ext);
    end

    assign accept = start && !busy;

    always_comb
    begin
        load.slot        = slot;
        load.weight      = weight;
        load.line_energy = line_energy;
        load.bin_we      = accept && (action == ACT_LOAD_BIN)
                           && (32'(slot) < 32'(MAX_BINS));
        load.line_we     = accept && (action == ACT_LOAD_LINE)
                           && (32'(slot) < 32'(MAX_LINES));
    end

    ses_cont_store #(
        .MAX_BINS   (MAX_BINS)
    ) u_cont_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .rd_addr    (bin_rd_addr),
        .rd_data    (bin_rd_data),
        .cont_total (cont_total),
        .bin_peak   (bin_peak)
    );

    ses_line_store #(
        .MAX_LINES  (MAX_LINES)
    ) u_line_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .rd_addr    (line_rd_addr),
        .rd_data    (line_rd_data),
        .disc_total (disc_total)
    );

    ses_draw_ctrl #(
        .MAX_BINS     (MAX_BINS),
        .MAX_LINES    (MAX_LINES),
        .RAND_BITS    (RAND_BITS)
    ) u_draw_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .action       (action),
        .rand_part    (rand_part),
        .rand_energy  (rand_energy),
        .rand_accept  (rand_accept),
        .bins_used    (bins_used),
        .lines_used   (lines_used),
        .cont_total   (cont_total),
        .disc_total   (disc_total),
        .bin_peak     (bin_peak),
        .bin_rd_data  (bin_rd_data),
        .line_rd_data (line_rd_data),
        .bin_rd_addr  (bin_rd_addr),
        .line_rd_addr (line_rd_addr),
        .busy         (busy),
        .done         (done),
        .energy       (energy),
        .status       (status)
    );

endmodule

`default_nettype wire

[design/ses_cont_store.sv]
// continuous bin weight memory with running total and peak weight
`default_nettype none

module ses_cont_store #(
    parameter int MAX_BINS = ses_pkg::DEF_MAX_BINS
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire ses_pkg::ses_load_t                        load,
    input  wire logic [ses_pkg::addr_w(MAX_BINS)-1:0]      rd_addr,
    output logic      [ses_pkg::WEIGHT_W-1:0]              rd_data,
    output logic      [ses_pkg::CTOT_W-1:0]                cont_total,
    output logic      [ses_pkg::WEIGHT_W-1:0]              bin_peak
);
    import ses_pkg::*;

    localparam int BA_W = addr_w(MAX_BINS);

    logic [WEIGHT_W-1:0] bin_mem [MAX_BINS];
    logic [WEIGHT_W-1:0] rd_data_reg;
    logic [CTOT_W-1:0]   total_reg;
    logic [CTOT_W-1:0]   total_next;
    logic [WEIGHT_W-1:0] peak_reg;
    logic [WEIGHT_W-1:0] peak_next;
    logic [CTOT_W-1:0]   total_base;
    logic [WEIGHT_W-1:0] peak_base;
    logic [CTOT_W:0]     total_sum;
    logic [BA_W-1:0]     wr_addr;

    assign wr_addr = BA_W'(load.slot);

    always_comb
    begin
        total_base = (load.slot == '0) ? '0 : total_reg;
        peak_base  = (load.slot == '0) ? '0 : peak_reg;
        total_sum  = (CTOT_W + 1)'(total_base) + (CTOT_W + 1)'(load.weight);
        total_next = total_sum[CTOT_W] ? {CTOT_W{1'b1}} : total_sum[CTOT_W-1:0];
        peak_next  = (load.weight > peak_base) ? load.weight : peak_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            peak_reg  <= '0;
        end
        else if (load.bin_we)
        begin
            total_reg <= total_next;
            peak_reg  <= peak_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.bin_we)
        begin
            bin_mem[wr_addr] <= load.weight;
        end
        rd_data_reg <= bin_mem[rd_addr];
    end

    assign rd_data    = rd_data_reg;
    assign cont_total = total_reg;
    assign bin_peak   = peak_reg;

endmodule

`default_nettype wire

[design/ses_line_store.sv]
// discrete line memory holding energy and cumulative weight per line
`default_nettype none

module ses_line_store #(
    parameter int MAX_LINES = ses_pkg::DEF_MAX_LINES
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire ses_pkg::ses_load_t                        load,
    input  wire logic [ses_pkg::addr_w(MAX_LINES)-1:0]     rd_addr,
    output ses_pkg::ses_line_t                             rd_data,
    output logic      [ses_pkg::DTOT_W-1:0]                disc_total
);
    import ses_pkg::*;

    localparam int LA_W = addr_w(MAX_LINES);

    ses_line_t         line_mem [MAX_LINES];
    ses_line_t         rd_data_reg;
    ses_line_t         wr_data;
    logic [DTOT_W-1:0] total_reg;
    logic [DTOT_W-1:0] total_next;
    logic [DTOT_W-1:0] total_base;
    logic [DTOT_W:0]   total_sum;
    logic [LA_W-1:0]   wr_addr;

    assign wr_addr = LA_W'(load.slot);

    always_comb
    begin
        total_base     = (load.slot == '0) ? '0 : total_reg;
        total_sum      = (DTOT_W + 1)'(total_base) + (DTOT_W + 1)'(load.weight);
        total_next     = total_sum[DTOT_W] ? {DTOT_W{1'b1}} : total_sum[DTOT_W-1:0];
        wr_data.energy = load.line_energy;
        wr_data.cum    = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else if (load.line_we)
        begin
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.line_we)
        begin
            line_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= line_mem[rd_addr];
    end

    assign rd_data    = rd_data_reg;
    assign disc_total = total_reg;

endmodule

`default_nettype wire

[design/ses_draw_ctrl.sv]
// draw sequencer: part choice, rejection trial and cumulative line walk
`default_nettype none

module ses_draw_ctrl #(
    parameter int MAX_BINS  = ses_pkg::DEF_MAX_BINS,
    parameter int MAX_LINES = ses_pkg::DEF_MAX_LINES,
    parameter int RAND_BITS = ses_pkg::DEF_RAND_BITS
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      start,
    input  wire logic [ses_pkg::ACTION_W-1:0]              action,
    input  wire logic [ses_pkg::RAND_W-1:0]                rand_part,
    input  wire logic [ses_pkg::RAND_W-1:0]                rand_energy,
    input  wire logic [ses_pkg::RAND_W-1:0]                rand_accept,
    input  wire logic [$clog2(MAX_BINS + 1)-1:0]           bins_used,
    input  wire logic [$clog2(MAX_LINES + 1)-1:0]          lines_used,
    input  wire logic [ses_pkg::CTOT_W-1:0]                cont_total,
    input  wire logic [ses_pkg::DTOT_W-1:0]                disc_total,
    input  wire logic [ses_pkg::WEIGHT_W-1:0]              bin_peak,
    input  wire logic [ses_pkg::WEIGHT_W-1:0]              bin_rd_data,
    input  wire ses_pkg::ses_line_t                        line_rd_data,
    output logic      [ses_pkg::addr_w(MAX_BINS)-1:0]      bin_rd_addr,
    output logic      [ses_pkg::addr_w(MAX_LINES)-1:0]     line_rd_addr,
    output logic                                           busy,
    output logic                                           done,
    output logic      [ses_pkg::ENERGY_W-1:0]              energy,
    output logic      [ses_pkg::STATUS_W-1:0]              status
);
    import ses_pkg::*;

    localparam int RW   = RAND_BITS;
    localparam int PW   = RW + TOT_W;
    localparam int BA_W = addr_w(MAX_BINS);
    localparam int LA_W = addr_w(MAX_LINES);
    localparam int N_W  = $clog2(MAX_BINS + 1);
    localparam int M_W  = $clog2(MAX_LINES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PMUL  = 3'd1;
    localparam logic [2:0] S_PCMP  = 3'd2;
    localparam logic [2:0] S_BMUL  = 3'd3;
    localparam logic [2:0] S_BRD   = 3'd4;
    localparam logic [2:0] S_BCMP  = 3'd5;
    localparam logic [2:0] S_DMUL  = 3'd6;
    localparam logic [2:0] S_DWALK = 3'd7;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [LA_W-1:0]     walk_reg;
    logic [LA_W-1:0]     walk_next;
    logic                done_reg;
    logic                done_next;
    logic [ENERGY_W-1:0] energy_reg;
    logic [ENERGY_W-1:0] energy_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [RW-1:0]       rp_reg;
    logic [RW-1:0]       re_reg;
    logic [RW-1:0]       ra_reg;
    logic [PW-1:0]       prod_reg;
    logic [ENERGY_W-1:0] epend_reg;

    logic                draw_go;
    logic [CTOT_W-1:0]   cw;
    logic [DTOT_W-1:0]   dw;
    logic [TOT_W-1:0]    total;
    logic                part_cont;
    logic [RW-1:0]       mul_a;
    logic [TOT_W-1:0]    mul_b;
    logic                mul_en;
    logic [PW-1:0]       bin_full;
    logic [PW+7:0]       pos_full;
    logic [18:0]         pos_mid;
    logic [ENERGY_W-1:0] pos_sat;
    logic                reject;
    logic                hit;
    logic                last;

    assign busy    = (state_reg != S_IDLE);
    assign draw_go = start && !busy && (action == ACT_DRAW);

    always_comb
    begin
        cw        = (bins_used != '0) ? cont_total : '0;
        dw        = (lines_used != '0) ? disc_total : '0;
        total     = TOT_W'(cw) + TOT_W'(dw);
        part_cont = prod_reg < PW'({cw, {RW{1'b0}}});
        bin_full  = prod_reg >> RW;
        pos_full  = {prod_reg, 8'd0} >> RW;
        pos_mid   = 19'(pos_full) + 19'd128;
        pos_sat   = pos_mid[18:17] != 2'b00 ? {ENERGY_W{1'b1}} : pos_mid[16:0];
        reject    = PW'({bin_rd_data, {RW{1'b0}}}) < prod_reg;
        hit       = prod_reg < PW'({line_rd_data.cum, {RW{1'b0}}});
        last      = M_W'(walk_reg) == (lines_used - M_W'(1));
    end

    assign bin_rd_addr  = bin_full[BA_W-1:0];
    assign line_rd_addr = (state_reg == S_DMUL) ? '0 : walk_reg + LA_W'(1);

    // shared multiplier operand select
    always_comb
    begin
        mul_a  = re_reg;
        mul_b  = TOT_W'(disc_total);
        mul_en = 1'b0;
        unique case (state_reg)
            S_PMUL:
            begin
                mul_a  = rp_reg;
                mul_b  = total;
                mul_en = 1'b1;
            end
            S_BMUL:
            begin
                mul_a  = re_reg;
                mul_b  = TOT_W'(bins_used);
                mul_en = 1'b1;
            end
            S_BRD:
            begin
                mul_a  = ra_reg;
                mul_b  = TOT_W'(bin_peak);
                mul_en = 1'b1;
            end
            S_DMUL:
            begin
                mul_a  = re_reg;
                mul_b  = TOT_W'(disc_total);
                mul_en = 1'b1;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        walk_next   = walk_reg;
        done_next   = 1'b0;
        energy_next = energy_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (draw_go)
                begin
                    if (total == '0)
                    begin
                        done_next   = 1'b1;
                        energy_next = '0;
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        state_next = S_PMUL;
                    end
                end
            end
            S_PMUL:
            begin
                state_next = S_PCMP;
            end
            S_PCMP:
            begin
                state_next = part_cont ? S_BMUL : S_DMUL;
            end
            S_BMUL:
            begin
                state_next = S_BRD;
            end
            S_BRD:
            begin
                state_next = S_BCMP;
            end
            S_BCMP:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (reject)
                begin
                    energy_next = '0;
                    status_next = STAT_RETRY;
                end
                else
                begin
                    energy_next = epend_reg;
                    status_next = STAT_CONT;
                end
            end
            S_DMUL:
            begin
                walk_next  = '0;
                state_next = S_DWALK;
            end
            S_DWALK:
            begin
                if (hit || last)
                begin
                    done_next   = 1'b1;
                    energy_next = ENERGY_W'(line_rd_data.energy);
                    status_next = STAT_LINE;
                    state_next  = S_IDLE;
                end
                else
                begin
                    walk_next = walk_reg + LA_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            walk_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        energy_reg <= energy_next;
        status_reg <= status_next;
        if (draw_go)
        begin
            rp_reg <= RW'(rand_part);
            re_reg <= RW'(rand_energy);
            ra_reg <= RW'(rand_accept);
        end
        if (mul_en)
        begin
            prod_reg <= PW'(mul_a) * PW'(mul_b);
        end
        if (state_reg == S_BRD)
        begin
            epend_reg <= pos_sat;
        end
    end

    assign done   = done_reg;
    assign energy = energy_reg;
    assign status = status_reg;

endmodule

`default_nettype wire
